@@ hw/rtl/double_ended_queue_core_defines.svh @@
// ----------------------------------------------------------------------------
// double-ended queue core assertion macros
// shared concurrent check forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define DQC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqc check failed");

// next-cycle implication
`define DQC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqc check failed");

`endif

@@ hw/rtl/dqc_pkg.sv @@
// ----------------------------------------------------------------------------
// dqc_pkg
// sizes, operation and status codes and the cell control struct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dqc_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                     shift_back;   // push front: every entry moves one cell back
    logic                     shift_front;  // pop front: every entry moves one cell forward
    logic                     write_back;   // push back: one cell takes the value
    logic [IDX_W-1:0]         write_idx;
    logic [IDX_W-1:0]         read_idx;
    logic signed [DATA_W-1:0] value;
  } dqc_ctrl_t;

endpackage

@@ hw/rtl/dqc_cell.sv @@
// ----------------------------------------------------------------------------
// dqc_cell
// one storage slot of the queue row; trades its word with its neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dqc_cell import dqc_pkg::*; (
  input  logic                     clk,
  input  dqc_ctrl_t                ctrl,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [DATA_W-1:0] front_data,
  input  logic signed [DATA_W-1:0] back_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_back) begin
      data_nxt = front_data;
    end else if (ctrl.shift_front) begin
      data_nxt = back_data;
    end else if (ctrl.write_back && (ctrl.write_idx == idx)) begin
      data_nxt = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // gated so the row can be or-ed together
  assign tap  = (ctrl.read_idx == idx) ? data_r : '0;

endmodule

@@ hw/rtl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// bounded deque of signed words kept packed in a row of cells, front in cell 0
// ----------------------------------------------------------------------------
//   channel   ports                                       handshake
//   input     in_kind, in_value                           start && !busy
//   result    out_popped, out_status, out_occupancy       out_valid strobe
//
// one operation per cycle; busy never rises
// the result strobes in the cycle after its beat, from the output register
// the cell row shifts, writes or is tapped in the same cycle the beat lands
// reset empties the queue; cell contents are not cleared
// results cannot be held off, so nothing stalls
`timescale 1ns / 1ps

`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core import dqc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_popped,
  output logic [STAT_W-1:0]        out_status,
  output logic [OCC_W-1:0]         out_occupancy
);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_popped_r;
  logic signed [DATA_W-1:0] out_popped_nxt;
  logic [STAT_W-1:0]        out_status_r;
  logic [STAT_W-1:0]        out_status_nxt;
  logic [OCC_W-1:0]         out_occupancy_r;

  logic                     beat;
  logic                     is_push;
  logic                     full;
  logic                     empty;
  logic                     ok;
  logic signed [DATA_W-1:0] popped_or;
  dqc_ctrl_t                ctrl;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap  [DEPTH];

  assign busy    = 1'b0;
  assign beat    = start && !busy;
  assign is_push = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_BACK);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign ok      = beat && (is_push ? !full : !empty);

  always_comb begin
    ctrl             = '0;
    ctrl.value       = in_value;
    ctrl.write_idx   = IDX_W'(count_r);
    ctrl.shift_back  = ok && (in_kind == KIND_PUSH_FRONT);
    ctrl.write_back  = ok && (in_kind == KIND_PUSH_BACK);
    ctrl.shift_front = ok && (in_kind == KIND_POP_FRONT);
    // last held entry sits at count-1
    ctrl.read_idx    = (in_kind == KIND_POP_BACK) ? IDX_W'(count_r - CNT_W'(1)) : '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] from_front;
    logic signed [DATA_W-1:0] from_back;
    if (i == 0) begin : g_head
      assign from_front = in_value;
    end else begin : g_mid_f
      assign from_front = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign from_back = cell_data[i];
    end else begin : g_mid_b
      assign from_back = cell_data[i+1];
    end
    dqc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .front_data (from_front),
      .back_data  (from_back),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  always_comb begin
    popped_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      popped_or = popped_or | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt      = count_r;
    out_popped_nxt = '0;
    out_status_nxt = ST_OK;
    if (beat) begin
      if (is_push) begin
        if (full) begin
          out_status_nxt = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_UNDERFLOW;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          out_popped_nxt = popped_or;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_popped_r    <= out_popped_nxt;
      out_status_r    <= out_status_nxt;
      out_occupancy_r <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_popped    = out_popped_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  `DQC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `DQC_ASSERT_NEXT(a_beat_strobe, beat, out_valid_r)
  `DQC_ASSERT_NEXT(a_push_grows, ok && is_push, count_r == $past(count_r) + CNT_W'(1))
  `DQC_ASSERT_NOW(a_underflow_zero, out_valid_r && (out_status_r == ST_UNDERFLOW),
                  (out_popped_r == '0) && (out_occupancy_r == '0))

endmodule
